// ===== rtl/core/lfu_pkg.sv =====
`timescale 1ns / 1ps
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_BITS  = 16;
    localparam int STAMP_BITS  = 48;
    localparam int WORD_BITS   = 32;
    localparam int CAP_W       = 5;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [OCC_W-1:0]      t_occ;
    typedef logic [CAP_W-1:0]      t_cap;

    localparam t_cap   CAP_RESET = CAP_W'(16);
    localparam t_count COUNT_MAX = '1;

    // request kinds
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // entry update kinds
    localparam logic UPD_BUMP   = 1'b0;
    localparam logic UPD_INSERT = 1'b1;

    // partial search result handed from cell to cell
    typedef struct packed {
        t_word  key;
        logic   match_found;
        t_idx   match_idx;
        t_word  match_val;
        logic   vic_found;
        t_idx   vic_idx;
        t_word  vic_key;
        t_count vic_count;
        t_stamp vic_stamp;
        logic   free_found;
        t_idx   free_idx;
    } t_scan;

    // entry write command broadcast to the row
    typedef struct packed {
        logic   en;
        logic   kind;
        logic   set_value;
        t_idx   idx;
        t_word  key;
        t_word  value;
        t_stamp stamp;
    } t_upd;

endpackage

// ===== rtl/core/lfu_if.sv =====
`timescale 1ns / 1ps
interface lfu_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, operation, key, value, input ready);
    modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lfu_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== rtl/core/lfu_cell.sv =====
`timescale 1ns / 1ps
module lfu_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lfu_pkg::t_idx  i_idx,
    input  logic           i_tok,
    input  lfu_pkg::t_scan i_scan,
    input  lfu_pkg::t_upd  i_upd,
    output logic           o_tok,
    output lfu_pkg::t_scan o_scan
);

    logic            r_valid;
    lfu_pkg::t_word  r_key;
    lfu_pkg::t_word  r_value;
    lfu_pkg::t_count r_count;
    lfu_pkg::t_stamp r_stamp;

    logic            r_tok;
    lfu_pkg::t_scan  r_scan;
    lfu_pkg::t_scan  n_scan;

    logic w_sel;
    logic w_better;

    assign w_sel    = i_upd.en && (i_upd.idx == i_idx);
    assign w_better = !i_scan.vic_found || (r_count < i_scan.vic_count) ||
                      ((r_count == i_scan.vic_count) && (r_stamp < i_scan.vic_stamp));

    // fold this entry into the running search
    always_comb begin
        n_scan = i_scan;
        if (r_valid && (r_key == i_scan.key) && !i_scan.match_found) begin
            n_scan.match_found = 1'b1;
            n_scan.match_idx   = i_idx;
            n_scan.match_val   = r_value;
        end
        if (r_valid && w_better) begin
            n_scan.vic_found = 1'b1;
            n_scan.vic_idx   = i_idx;
            n_scan.vic_key   = r_key;
            n_scan.vic_count = r_count;
            n_scan.vic_stamp = r_stamp;
        end
        if (!r_valid && !i_scan.free_found) begin
            n_scan.free_found = 1'b1;
            n_scan.free_idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (w_sel && (i_upd.kind == lfu_pkg::UPD_INSERT)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (w_sel) begin
            case (i_upd.kind)
                lfu_pkg::UPD_INSERT: begin
                    r_key   <= i_upd.key;
                    r_value <= i_upd.value;
                    r_count <= lfu_pkg::t_count'(1);
                    r_stamp <= i_upd.stamp;
                end
                lfu_pkg::UPD_BUMP: begin
                    if (i_upd.set_value) begin
                        r_value <= i_upd.value;
                    end
                    if (r_count != lfu_pkg::COUNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_stamp <= i_upd.stamp;
                end
                default: begin
                    r_stamp <= r_stamp;
                end
            endcase
        end
    end

    assign o_tok  = r_tok;
    assign o_scan = r_scan;

endmodule

// ===== rtl/core/lfu_cache_engine.sv =====
`timescale 1ns / 1ps
// The search token walks the row of MAX_ENTRIES cells, one cell per cycle. As it
// leaves the row the entry is written and the result registered; the result then
// moves to the output register, and only after that is a new item accepted.
// A stalled output holds the result back from the output register.
// Reset (synchronous, active low): all entries invalid, occupancy and stamp
// counter zero, capacity 16, no result pending.
module lfu_cache_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_data,
    lfu_req_if.sink                i_req,
    lfu_rsp_if.source              o_rsp
);

    localparam int N     = lfu_pkg::MAX_ENTRIES;
    localparam int CMP_W = lfu_pkg::CAP_W + lfu_pkg::OCC_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    lfu_pkg::t_cap   r_capacity;
    lfu_pkg::t_occ   r_occ;
    lfu_pkg::t_occ   n_occ;
    lfu_pkg::t_stamp r_stamp_ctr;

    // latched request
    logic            r_op;
    lfu_pkg::t_word  r_value;

    // finished result, before and in the output register
    logic            r_res_hit;
    lfu_pkg::t_word  r_res_read;
    logic            r_res_evicted;
    lfu_pkg::t_word  r_res_evkey;
    logic            n_res_hit;
    lfu_pkg::t_word  n_res_read;
    logic            n_res_evicted;
    lfu_pkg::t_word  n_res_evkey;

    logic            r_out_valid;
    logic            r_out_hit;
    lfu_pkg::t_word  r_out_read;
    logic            r_out_evicted;
    lfu_pkg::t_word  r_out_evkey;

    // chain wiring
    logic            w_tok  [0:N];
    lfu_pkg::t_scan  w_scan [0:N];
    logic [N-1:0]    w_tok_vec;
    lfu_pkg::t_upd   w_upd;
    lfu_pkg::t_scan  w_res;

    logic            w_accept;
    logic            w_done;
    logic            w_out_free;
    logic [CMP_W-1:0] w_cap_eff;
    logic             w_full;

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_done     = (r_state == S_SCAN) && w_tok[N];
    assign w_res      = w_scan[N];
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // clamp capacity to the row size
    assign w_cap_eff = (CMP_W'(r_capacity) > CMP_W'(N)) ? CMP_W'(N) : CMP_W'(r_capacity);
    assign w_full    = CMP_W'(r_occ) >= w_cap_eff;

    // launch the search at cell 0 straight from the input channel
    always_comb begin
        w_scan[0]     = '0;
        w_scan[0].key = i_req.key;
    end
    assign w_tok[0] = w_accept;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            lfu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (lfu_pkg::t_idx'(g)),
                .i_tok   (w_tok[g]),
                .i_scan  (w_scan[g]),
                .i_upd   (w_upd),
                .o_tok   (w_tok[g+1]),
                .o_scan  (w_scan[g+1])
            );
            assign w_tok_vec[g] = w_tok[g+1];
        end
    endgenerate

    // decide the entry write and the result once the token leaves the row
    always_comb begin
        w_upd         = '0;
        w_upd.key     = w_res.key;
        w_upd.value   = r_value;
        w_upd.stamp   = r_stamp_ctr;
        n_occ         = r_occ;
        n_res_hit     = w_res.match_found;
        n_res_read    = '0;
        n_res_evicted = 1'b0;
        n_res_evkey   = '0;
        if (w_done) begin
            if (r_op == lfu_pkg::OP_GET) begin
                if (w_res.match_found) begin
                    n_res_read = w_res.match_val;
                    w_upd.en   = 1'b1;
                    w_upd.kind = lfu_pkg::UPD_BUMP;
                    w_upd.idx  = w_res.match_idx;
                end else begin
                    n_res_read = '1;
                end
            end else if (r_capacity != '0) begin
                if (w_res.match_found) begin
                    // rewrite value and raise count
                    w_upd.en        = 1'b1;
                    w_upd.kind      = lfu_pkg::UPD_BUMP;
                    w_upd.set_value = 1'b1;
                    w_upd.idx       = w_res.match_idx;
                end else if (w_full && w_res.vic_found) begin
                    // evict the victim and reuse its slot
                    n_res_evicted = 1'b1;
                    n_res_evkey   = w_res.vic_key;
                    w_upd.en      = 1'b1;
                    w_upd.kind    = lfu_pkg::UPD_INSERT;
                    w_upd.idx     = w_res.vic_idx;
                end else if (w_res.free_found) begin
                    w_upd.en   = 1'b1;
                    w_upd.kind = lfu_pkg::UPD_INSERT;
                    w_upd.idx  = w_res.free_idx;
                    n_occ      = r_occ + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[N]) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= lfu_pkg::CAP_RESET;
            r_occ       <= '0;
            r_stamp_ctr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            // advance the stamp on every entry write
            if (w_upd.en) begin
                r_stamp_ctr <= r_stamp_ctr + 1'b1;
            end
            if ((r_state == S_PUSH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_req.operation;
            r_value <= i_req.value;
        end
        if (w_done) begin
            r_res_hit     <= n_res_hit;
            r_res_read    <= n_res_read;
            r_res_evicted <= n_res_evicted;
            r_res_evkey   <= n_res_evkey;
        end
        if ((r_state == S_PUSH) && w_out_free) begin
            r_out_hit     <= r_res_hit;
            r_out_read    <= r_res_read;
            r_out_evicted <= r_res_evicted;
            r_out_evkey   <= r_res_evkey;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_read;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_evkey;

`ifndef SYNTHESIS
    // at most one search token in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one search token in flight");

    // a token leaves the row only while a search is running
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[N] |-> (r_state == S_SCAN))
        else $error("search token outside scan state");

    // an accepted item starts a search
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && w_tok[1])
        else $error("accepted item did not start a search");

    // occupancy never exceeds the row
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lfu_pkg::t_occ'(N))
        else $error("occupancy above row size");

    // occupancy grows by at most one per item and never shrinks
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + 1'b1)))
        else $error("occupancy stepped wrongly");
`endif

endmodule

// ===== bench/lfu_cache_checker.sv =====
`timescale 1ns / 1ps
module lfu_cache_checker import lfu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  t_cap i_cfg_data,
    lfu_req_if   i_req,
    lfu_rsp_if   i_rsp,
    output int   o_pending,
    output int   o_fail_count
);

    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic  hit;
        t_word read_value;
        logic  evicted;
        t_word evicted_key;
    } t_outcome;

    // Shadow copy of the store.
    logic   slot_used  [MAX_ENTRIES];
    t_word  slot_key   [MAX_ENTRIES];
    t_word  slot_val   [MAX_ENTRIES];
    t_count slot_uses  [MAX_ENTRIES];
    t_stamp slot_stamp [MAX_ENTRIES];
    t_stamp stamp_now;
    int     fill;
    t_cap   cap_reg;

    t_outcome lookup_results_q[$];
    t_outcome want;
    int       fail_total;

    task automatic flag_error(input string msg);
        if (fail_total < PRINT_LIMIT) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        fail_total++;
    endtask

    // Raise the use count (saturating) and restamp the entry.
    function automatic void refresh_entry(input int i);
        if (slot_uses[i] != COUNT_MAX) begin
            slot_uses[i]++;
        end
        slot_stamp[i] = stamp_now;
        stamp_now++;
    endfunction

    function automatic t_outcome predict_lookup(input logic op, input t_word k, input t_word v);
        t_outcome res;
        int       found;
        int       room;
        int       slot;
        res   = '0;
        found = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (found < 0 && slot_used[i] && slot_key[i] == k) begin
                found = i;
            end
        end
        res.hit = (found >= 0);
        room    = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);

        if (op == OP_GET) begin
            if (found >= 0) begin
                res.read_value = slot_val[found];
                refresh_entry(found);
            end else begin
                res.read_value = '1;
            end
            return res;
        end

        // Zero capacity: puts leave the store alone.
        if (room == 0) begin
            return res;
        end
        if (found >= 0) begin
            slot_val[found] = v;
            refresh_entry(found);
            return res;
        end

        // New key into a full store: drop the least used, oldest stamp first.
        // Only one victim goes even when occupancy sits above capacity.
        slot = -1;
        if (fill >= room) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot_used[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                    (slot_uses[i] == slot_uses[slot] && slot_stamp[i] < slot_stamp[slot]))) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                res.evicted     = 1'b1;
                res.evicted_key = slot_key[slot];
                slot_used[slot] = 1'b0;
                fill--;
            end
        end
        if (slot < 0) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot < 0 && !slot_used[i]) begin
                    slot = i;
                end
            end
        end
        if (slot >= 0) begin
            slot_used[slot]  = 1'b1;
            slot_key[slot]   = k;
            slot_val[slot]   = v;
            slot_uses[slot]  = t_count'(1);
            slot_stamp[slot] = stamp_now;
            stamp_now++;
            fill++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
            end
            stamp_now  = '0;
            fill       = 0;
            cap_reg    = CAP_RESET;
            fail_total = 0;
            lookup_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                cap_reg = i_cfg_data;
            end
            if (i_req.valid && i_req.ready) begin
                lookup_results_q.push_back(predict_lookup(i_req.operation, i_req.key,
                                                          i_req.value));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (lookup_results_q.size() == 0) begin
                    flag_error("result with no request outstanding");
                end else begin
                    want = lookup_results_q.pop_front();
                    if (i_rsp.hit !== want.hit) begin
                        flag_error($sformatf("hit: got %b, want %b", i_rsp.hit, want.hit));
                    end
                    if (i_rsp.read_value !== want.read_value) begin
                        flag_error($sformatf("read_value: got %h, want %h",
                                             i_rsp.read_value, want.read_value));
                    end
                    if (i_rsp.evicted !== want.evicted) begin
                        flag_error($sformatf("evicted: got %b, want %b",
                                             i_rsp.evicted, want.evicted));
                    end
                    if (i_rsp.evicted_key !== want.evicted_key) begin
                        flag_error($sformatf("evicted_key: got %h, want %h",
                                             i_rsp.evicted_key, want.evicted_key));
                    end
                end
            end
        end
        o_pending    <= lookup_results_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import lfu_pkg::*;

    // Cycles without any handshake before the run is declared hung. The slowest
    // legal stretch is a long send gap plus a full search plus a long
    // response stall, well under this.
    localparam int STALL_LIMIT   = 2000;
    // Quiet cycles after the last result before touching capacity or ending.
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 165;

    localparam t_word WORD_MIN  = 32'h8000_0000;
    localparam t_word WORD_MAX  = 32'h7FFF_FFFF;
    localparam t_word WORD_ONES = 32'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_cap cfg_data;
    int   pending;
    int   fail_count;
    bit   sender_calm;
    int   idle_cycles;

    // Keys in play for the current phase; reuse keeps hits and evictions common.
    t_word key_pool[$];

    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();

    lfu_cache_engine dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    lfu_cache_checker lookup_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #2 clk = ~clk;

    // Mostly short gaps, some medium, a few long enough to outlast a search.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        if (r < 96) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(21, 60);
    endfunction

    // Random word with the sign and boundary patterns thrown in now and then.
    function automatic t_word any_word();
        case ($urandom_range(0, 39))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Hold the request until the block takes it. Keep valid high across
    // back-to-back items; lower it only when a gap is inserted.
    task automatic send_item(input logic op, input t_word k, input t_word v);
        int gap;
        gap = 0;
        if ($urandom_range(0, 149) == 0) begin
            sender_calm = !sender_calm;
        end
        if (!sender_calm && $urandom_range(0, 2) == 0) begin
            gap = gap_length();
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= k;
        req_ch.value     <= v;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stop sending, drain every outstanding result, then let the block go quiet.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Capacity changes only while the engine is idle.
    task automatic write_capacity(input t_cap c);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random phase at a given capacity. Carry up to half of the new pool
    // over from the previous one so that shrinking or zero capacity still sees stored keys.
    task automatic run_phase(input t_cap c, input int n);
        int    room;
        int    target;
        t_word k;
        write_capacity(c);
        room   = (c > MAX_ENTRIES) ? MAX_ENTRIES : int'(c);
        target = room + $urandom_range(1, 6);
        while (key_pool.size() > target / 2) key_pool.pop_front();
        while (key_pool.size() < target) key_pool.push_back(any_word());
        repeat (n) begin
            if ($urandom_range(0, 99) < 85) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else begin
                k = $urandom;
            end
            send_item(1'($urandom_range(0, 1)), k, any_word());
            // Now and then let the pipeline run dry mid-phase.
            if ($urandom_range(0, 119) == 0) begin
                settle();
            end
        end
    endtask

    // Response side: random stalls, with calm stretches where ready stays high.
    initial begin : rsp_stall
        int stall_left;
        bit calm;
        stall_left = 0;
        calm       = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0) begin
                calm = !calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = gap_length() - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: reset the count on any handshake, give up when it runs out.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL lfu_cache_engine");
        $finish;
    end

    initial begin
        sender_calm = 1'b0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_data         <= CAP_RESET;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_GET;
        req_ch.key       <= '0;
        req_ch.value     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset capacity: get on an empty store misses and reads all ones.
        send_item(OP_GET, '0, WORD_MAX);
        // Insert the most negative and most positive keys.
        send_item(OP_PUT, WORD_MIN, WORD_MAX);
        send_item(OP_PUT, WORD_MAX, WORD_MIN);
        send_item(OP_GET, WORD_MIN, '0);
        // Rewrite a present key; the count goes up, no eviction.
        send_item(OP_PUT, WORD_MAX, WORD_ONES);
        // Key of all ones is not stored: the miss looks like the stored -1 below.
        send_item(OP_GET, WORD_ONES, WORD_ONES);
        send_item(OP_PUT, '0, '0);
        send_item(OP_GET, WORD_MAX, '0);

        // Zero capacity: puts change nothing, gets still read what is stored.
        write_capacity('0);
        send_item(OP_PUT, 32'h1234_5678, 32'h0000_0001);
        send_item(OP_PUT, WORD_MIN, 32'h5555_5555);
        send_item(OP_GET, WORD_MIN, '0);
        send_item(OP_GET, 32'h1234_5678, '0);

        // Capacity lowered under occupancy: each new key evicts exactly one,
        // lowest count first, so the store stays over capacity.
        write_capacity(t_cap'(1));
        send_item(OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(OP_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_item(OP_PUT, 32'h0000_0001, WORD_MAX);
        send_item(OP_GET, 32'hA5A5_A5A5, '0);
        send_item(OP_GET, 32'h0000_0001, '0);

        // Random phases over a spread of capacities, extremes included.
        // Values above sixteen act as sixteen. Count saturation and stamp wrap
        // need far longer runs than this and are left to the predictor.
        run_phase(t_cap'(31), PHASE_ITEMS);
        run_phase(t_cap'(1), PHASE_ITEMS);
        run_phase(t_cap'(16), PHASE_ITEMS);
        run_phase('0, PHASE_ITEMS);
        run_phase(t_cap'(5), PHASE_ITEMS);
        run_phase(t_cap'(17), PHASE_ITEMS);
        run_phase(t_cap'($urandom_range(0, 31)), PHASE_ITEMS);
        run_phase(t_cap'(2), PHASE_ITEMS);

        settle();
        if (fail_count == 0) begin
            $display("PASS lfu_cache_engine");
        end else begin
            $display("FAIL lfu_cache_engine");
        end
        $finish;
    end

endmodule
